[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    localparam int ADDR_W = 4;

    localparam logic [ADDR_W-1:0] REG_TRIG_LEN = 4'h0;
    localparam logic [ADDR_W-1:0] REG_TIMEOUT  = 4'h4;
    localparam logic [ADDR_W-1:0] REG_CM_SCALE = 4'h8;

    localparam logic [7:0]  TRIG_LEN_RST = 8'd10;
    localparam logic [19:0] TIMEOUT_RST  = 20'd500000;
    localparam logic [15:0] CM_SCALE_RST = 16'd1127;

    localparam logic [14:0] INCH_SCALE = 15'd25802;
    localparam logic [14:0] CM_MAX     = 15'h7FFF;
    localparam logic [12:0] INCH_MAX   = 13'h1FFF;

endpackage

[rtl/ultrasonic_echo_ranger_top.sv]
// Top level of the ultrasonic echo ranger: sequencer, distance pipeline, config port.
//
// One input item per microsecond tick: s_tdata[0] start_req, s_tdata[1] echo_level.
// One result item per input item on the m_ side, in order.
// A start request while idle drives the trigger for trigger_len_us ticks, then the
// echo high time is counted; wait and count share one timeout from the trigger end.
// On the finishing tick the width is scaled to cm (width*cm_scale>>16) and inches
// (cm*25802>>16); both are held until the next measurement finishes.
// Throughput: one item per cycle; the pipeline is input reg, sequencer,
// cm multiply, inch multiply, output reg.
// If the receiver stalls, the whole pipeline holds and s_tready drops in the
// same cycle; no item is lost or repeated.
// Reset: sequencer idle, counters and held distances zero, config registers at
// 10 / 500000 / 1127, pipeline empty.
// Config: APB at 0x0 trigger_len_us, 0x4 timeout_us, 0x8 cm_scale; write only
// while no item is in flight.
module ultrasonic_echo_ranger_top #(
    parameter int COUNT_BITS = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata: [0] start_req, [1] echo_level, [7:2] zero
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    // m_tdata: [0] trigger_out, [1] busy_res, [2] done_res, [3] timed_out,
    // [23:4] echo_width_us, [38:24] distance_cm, [51:39] distance_inch, [55:52] zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [uer_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import uer_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 20) ? COUNT_BITS : 20;
    localparam int PW    = COUNT_BITS + 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // config registers
    logic [7:0]  trig_len_reg;
    logic [19:0] timeout_reg;
    logic [15:0] cm_scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_len_reg <= TRIG_LEN_RST;
            timeout_reg  <= TIMEOUT_RST;
            cm_scale_reg <= CM_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                REG_TRIG_LEN: trig_len_reg <= pwdata[7:0];
                REG_TIMEOUT:  timeout_reg  <= pwdata[19:0];
                REG_CM_SCALE: cm_scale_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_TRIG_LEN: prdata = {24'd0, trig_len_reg};
            REG_TIMEOUT:  prdata = {12'd0, timeout_reg};
            REG_CM_SCALE: prdata = {16'd0, cm_scale_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // pipeline advance
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: input register
    logic v1_reg, start1_reg, echo1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start1_reg <= s_tdata[0];
            echo1_reg  <= s_tdata[1];
        end
    end

    // stage 2: sequencer
    phase_t                phase_reg, phase_next;
    logic [7:0]            trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic                  trig_c, busy_c, done_c, tmo_c;
    logic [7:0]            trig_cnt_inc;

    always_comb
    begin
        phase_next    = phase_reg;
        trig_cnt_next = trig_cnt_reg;
        elapsed_next  = elapsed_reg;
        width_next    = width_reg;
        trig_c        = 1'b0;
        busy_c        = 1'b0;
        done_c        = 1'b0;
        tmo_c         = 1'b0;
        trig_cnt_inc  = 8'd0;

        if (phase_reg == PH_IDLE && start1_reg)
        begin
            phase_next    = PH_TRIG;
            trig_cnt_next = 8'd0;
        end

        unique case (phase_next)
            PH_TRIG:
            begin
                trig_c        = 1'b1;
                busy_c        = 1'b1;
                trig_cnt_inc  = (trig_cnt_next == 8'hFF) ? 8'hFF : trig_cnt_next + 8'd1;
                trig_cnt_next = trig_cnt_inc;
                if (trig_cnt_inc >= trig_len_reg)
                begin
                    phase_next   = PH_WAIT;
                    elapsed_next = '0;
                    width_next   = '0;
                end
            end
            PH_WAIT, PH_MEAS:
            begin
                busy_c = 1'b1;
                if (CMP_W'(elapsed_reg) >= CMP_W'(timeout_reg) || elapsed_reg == CNT_MAX)
                begin
                    done_c = 1'b1;
                    tmo_c  = 1'b1;
                end
                else if (echo1_reg)
                begin
                    width_next   = (width_reg == CNT_MAX) ? CNT_MAX :
                                   width_reg + COUNT_BITS'(1);
                    elapsed_next = elapsed_reg + COUNT_BITS'(1);
                    phase_next   = PH_MEAS;
                end
                else if (phase_reg == PH_MEAS)
                    done_c = 1'b1;
                else
                    elapsed_next = elapsed_reg + COUNT_BITS'(1);
                if (done_c)
                    phase_next = PH_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            trig_cnt_reg <= 8'd0;
            elapsed_reg  <= '0;
            width_reg    <= '0;
        end
        else if (en && v1_reg)
        begin
            phase_reg    <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            elapsed_reg  <= elapsed_next;
            width_reg    <= width_next;
        end
    end

    logic                  v2_reg, trig2_reg, busy2_reg, done2_reg, tmo2_reg;
    logic [COUNT_BITS-1:0] width2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig2_reg  <= trig_c;
            busy2_reg  <= busy_c;
            done2_reg  <= done_c;
            tmo2_reg   <= tmo_c;
            width2_reg <= width_next;
        end
    end

    // stage 3: width * cm_scale
    logic                  v3_reg, trig3_reg, busy3_reg, done3_reg, tmo3_reg;
    logic [19:0]           width3_reg;
    logic [PW-1:0]         prod3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig3_reg  <= trig2_reg;
            busy3_reg  <= busy2_reg;
            done3_reg  <= done2_reg;
            tmo3_reg   <= tmo2_reg;
            width3_reg <= 20'(CMP_W'(width2_reg));
            prod3_reg  <= PW'(width2_reg) * PW'(cm_scale_reg);
        end
    end

    // stage 4: cm saturate, cm * inch scale
    logic [COUNT_BITS-1:0] cm_raw;
    logic [14:0]           cm_sat;
    logic [14:0]           cm_hold_reg;
    logic                  v4_reg, trig4_reg, busy4_reg, done4_reg, tmo4_reg;
    logic [19:0]           width4_reg;
    logic [14:0]           cm4_reg;
    logic [29:0]           prod4_reg;

    assign cm_raw = prod3_reg[PW-1:16];
    assign cm_sat = (cm_raw > COUNT_BITS'(CM_MAX)) ? CM_MAX : cm_raw[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg      <= 1'b0;
            cm_hold_reg <= 15'd0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
            if (v3_reg && done3_reg)
                cm_hold_reg <= cm_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig4_reg  <= trig3_reg;
            busy4_reg  <= busy3_reg;
            done4_reg  <= done3_reg;
            tmo4_reg   <= tmo3_reg;
            width4_reg <= width3_reg;
            cm4_reg    <= done3_reg ? cm_sat : cm_hold_reg;
            prod4_reg  <= 30'(cm_sat) * 30'(INCH_SCALE);
        end
    end

    // stage 5: inch saturate, output register
    logic [13:0] inch_raw;
    logic [12:0] inch_sat;
    logic [12:0] inch_hold_reg;
    logic [55:0] m_data_reg;

    assign inch_raw = prod4_reg[29:16];
    assign inch_sat = (inch_raw > 14'(INCH_MAX)) ? INCH_MAX : inch_raw[12:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            inch_hold_reg <= 13'd0;
        end
        else if (en)
        begin
            m_valid_reg <= v4_reg;
            if (v4_reg && done4_reg)
                inch_hold_reg <= inch_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_data_reg <= {4'd0, (done4_reg ? inch_sat : inch_hold_reg), cm4_reg,
                           width4_reg, tmo4_reg, done4_reg, busy4_reg, trig4_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_tmo_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && tmo2_reg |-> done2_reg)
        else $error("timeout flagged without done");

    a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && done2_reg |-> busy2_reg && !trig2_reg)
        else $error("done outside a measurement");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(v4_reg))
        else $error("result without item in pipeline");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        en && v1_reg && done_c |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after done");
`endif

endmodule

[tb/sv/tb_ultrasonic_echo_ranger_top.sv]
// Self-checking testbench for the ultrasonic echo ranger: directed table and random ticks.
module tb_ultrasonic_echo_ranger_top;
    import uer_pkg::*;

    localparam int COUNT_W     = 20;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [12:0] inch;
        logic [14:0] cm;
        logic [19:0] width;
        logic        tmo;
        logic        done;
        logic        busy;
        logic        trig;
    } ranging_t;

    // trig+busy, and busy+done+timeout, both with zero width and distances
    localparam ranging_t RES_QUIET   = '0;
    localparam ranging_t RES_TRIGGER = ranging_t'(52'h3);
    localparam ranging_t RES_EMPTY   = ranging_t'(52'hE);

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [19:0]       value;
        logic              start;
        logic              echo;
        logic              typed;
        ranging_t          want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ultrasonic_echo_ranger_top #(.COUNT_BITS(COUNT_W)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dir_row_t dir_rows [0:28] = '{
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b1, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b1, RES_QUIET},
        '{ROW_CFG,  REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_CFG,  REG_TIMEOUT,  20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_CFG,  REG_CM_SCALE, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b1, 1'b1, RES_TRIGGER},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b1, 1'b1, RES_EMPTY},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b1, RES_QUIET},
        '{ROW_CFG,  REG_TRIG_LEN, 20'd2,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_CFG,  REG_TIMEOUT,  20'd5,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_CFG,  REG_CM_SCALE, 20'd65535, 1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b1, 1'b0, RES_QUIET},
        '{ROW_CFG,  REG_TIMEOUT,  20'd1,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b1, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b1, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET},
        '{ROW_TICK, REG_TRIG_LEN, 20'd0,     1'b0, 1'b0, 1'b0, RES_QUIET}
    };

    logic [7:0]         cfg_trig_len;
    logic [19:0]        cfg_timeout;
    logic [15:0]        cfg_cm_scale;
    phase_t             model_phase;
    logic [7:0]         model_trig_cnt;
    logic [COUNT_W-1:0] model_elapsed;
    logic [COUNT_W-1:0] model_width;
    logic [14:0]        model_cm;
    logic [12:0]        model_inch;

    ranging_t pending_ranges [$];
    int mismatch_count = 0;
    int ticks_sent     = 0;
    int ranges_done    = 0;
    int ranges_expired = 0;
    int reg_writes     = 0;
    int tx_gap_pct     = 0;
    int rx_stall_pct   = 0;
    int hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ranging_t range_tick(input logic start, input logic echo);
        ranging_t        r;
        longint unsigned cm_full;
        longint unsigned inch_full;
        r = '0;
        if (model_phase == PH_IDLE && start)
        begin
            model_phase    = PH_TRIG;
            model_trig_cnt = '0;
        end
        if (model_phase == PH_TRIG)
        begin
            r.trig = 1'b1;
            r.busy = 1'b1;
            if (model_trig_cnt != 8'hFF)
                model_trig_cnt++;
            if (model_trig_cnt >= cfg_trig_len)
            begin
                model_phase   = PH_WAIT;
                model_elapsed = '0;
                model_width   = '0;
            end
        end
        else if (model_phase != PH_IDLE)
        begin
            r.busy = 1'b1;
            if (model_elapsed >= cfg_timeout || model_elapsed == '1)
            begin
                r.done = 1'b1;
                r.tmo  = 1'b1;
            end
            else if (echo)
            begin
                if (model_width != '1)
                    model_width++;
                if (model_elapsed != '1)
                    model_elapsed++;
                model_phase = PH_MEAS;
            end
            else if (model_phase == PH_MEAS)
                r.done = 1'b1;
            else if (model_elapsed != '1)
                model_elapsed++;
            if (r.done)
            begin
                cm_full = 64'(model_width);
                cm_full = (cm_full * cfg_cm_scale) >> 16;
                if (cm_full > CM_MAX)
                    cm_full = CM_MAX;
                inch_full = (cm_full * INCH_SCALE) >> 16;
                if (inch_full > INCH_MAX)
                    inch_full = INCH_MAX;
                model_cm    = cm_full[14:0];
                model_inch  = inch_full[12:0];
                model_phase = PH_IDLE;
            end
        end
        r.width = model_width;
        r.cm    = model_cm;
        r.inch  = model_inch;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_range(input ranging_t got);
        ranging_t want;
        if (pending_ranges.size() == 0)
        begin
            log_mismatch("result item with nothing pending");
            return;
        end
        want = pending_ranges.pop_front();
        check_field("trigger_out", 64'(got.trig), 64'(want.trig));
        check_field("busy_res", 64'(got.busy), 64'(want.busy));
        check_field("done_res", 64'(got.done), 64'(want.done));
        check_field("timed_out", 64'(got.tmo), 64'(want.tmo));
        check_field("echo_width_us", 64'(got.width), 64'(want.width));
        check_field("distance_cm", 64'(got.cm), 64'(want.cm));
        check_field("distance_inch", 64'(got.inch), 64'(want.inch));
        ranges_done    += want.done;
        ranges_expired += want.tmo;
    endtask

    task automatic send_tick(input logic start, input logic echo, input logic typed,
                             input ranging_t want);
        logic     rdy;
        ranging_t predicted;
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, echo, start};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        predicted = range_tick(start, echo);
        pending_ranges.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== value)
            log_mismatch($sformatf("readback at %0h got %0h want %0h", addr, rd, value));
        case (addr)
            REG_TRIG_LEN: cfg_trig_len = value[7:0];
            REG_TIMEOUT:  cfg_timeout  = value[19:0];
            REG_CM_SCALE: cfg_cm_scale = value[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                check_range(m_tdata[51:0]);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a handshake", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int   p;
        int   counted;
        int   rise_pct;
        int   hold_pct;
        logic st;
        logic ec;
        logic [7:0]  t_len;
        logic [19:0] t_out;
        logic [15:0] scale;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rise_pct = 10;
        hold_pct = 80;

        cfg_trig_len   = TRIG_LEN_RST;
        cfg_timeout    = TIMEOUT_RST;
        cfg_cm_scale   = CM_SCALE_RST;
        model_phase    = PH_IDLE;
        model_trig_cnt = '0;
        model_elapsed  = '0;
        model_width    = '0;
        model_cm       = '0;
        model_inch     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].addr, 32'(dir_rows[i].value));
            else
                send_tick(dir_rows[i].start, dir_rows[i].echo, dir_rows[i].typed,
                          dir_rows[i].want);
        end

        // longest trigger, trigger counter at its top, full cm scale
        write_reg(REG_TRIG_LEN, 32'd255);
        write_reg(REG_TIMEOUT, 32'd100000);
        write_reg(REG_CM_SCALE, 32'd65535);
        send_tick(1'b1, 1'b0, 1'b0, RES_QUIET);
        while (model_phase == PH_TRIG)
            send_tick(1'b0, 1'b0, 1'b0, RES_QUIET);
        repeat (3) send_tick(1'b0, 1'b0, 1'b0, RES_QUIET);
        repeat (60) send_tick(1'b0, 1'b1, 1'b0, RES_QUIET);
        send_tick(1'b0, 1'b0, 1'b0, RES_QUIET);

        // echo still high when the timeout expires
        write_reg(REG_TRIG_LEN, 32'd1);
        write_reg(REG_TIMEOUT, 32'd64);
        write_reg(REG_CM_SCALE, 32'd1);
        send_tick(1'b1, 1'b1, 1'b0, RES_QUIET);
        while (model_phase != PH_IDLE)
            send_tick(1'b0, 1'b1, 1'b0, RES_QUIET);

        for (p = 0; p < 5; p++)
        begin
            t_len = 8'($urandom_range(12, 1));
            t_out = 20'($urandom_range(40, 1));
            scale = 16'($urandom_range(16'hFFFF, 1));
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
            case (p)
                0:
                begin
                    t_len = TRIG_LEN_RST;
                    t_out = TIMEOUT_RST;
                    scale = CM_SCALE_RST;
                end
                1:
                begin
                    t_len = 8'd1;
                    t_out = 20'd1;
                    scale = 16'd1;
                end
                default: ;
            endcase
            write_reg(REG_TRIG_LEN, 32'(t_len));
            write_reg(REG_TIMEOUT, 32'(t_out));
            write_reg(REG_CM_SCALE, 32'(scale));
            case (p)
                0: hold_left = 400;
                1: tx_gap_pct = 56;
                2: rx_stall_pct = 56;
                3:
                begin
                    tx_gap_pct   = 9;
                    rx_stall_pct = 9;
                end
                default: ;
            endcase

            counted = 0;
            while (counted < 160)
            begin
                st = 1'($urandom_range(1));
                ec = 1'($urandom_range(1));
                case (model_phase)
                    PH_IDLE:
                    begin
                        st = ($urandom_range(99) < 60);
                        if (st)
                        begin
                            rise_pct = (cfg_timeout <= 64 && $urandom_range(3) == 0) ?
                                       0 : int'($urandom_range(40, 3));
                            hold_pct = int'($urandom_range(97, 50));
                        end
                    end
                    PH_WAIT: ec = ($urandom_range(99) < rise_pct);
                    PH_MEAS: ec = ($urandom_range(99) < hold_pct);
                    default: ;
                endcase
                if (model_phase != PH_IDLE || st)
                    counted++;
                send_tick(st, ec, 1'b0, RES_QUIET);
            end
            // finish any open measurement before the next register writes
            while (model_phase != PH_IDLE)
                send_tick(1'b0, model_phase == PH_WAIT, 1'b0, RES_QUIET);
        end

        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_ranges.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_ranges.size()));

        $display("Run: %0d ticks, %0d register writes, five idling mixes and a long hold-off.",
                 ticks_sent, reg_writes);
        $display("Measurements finished: %0d, of which %0d by timeout; mismatches: %0d.",
                 ranges_done, ranges_expired, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/uer_pkg.sv
rtl/ultrasonic_echo_ranger_top.sv
tb/sv/tb_ultrasonic_echo_ranger_top.sv
